// ===== hw/rtl/prr_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and the unit interface type of the prescaler calculator.
package prr_pkg;

	localparam int PERIOD_W = 32;              // timer_period
	localparam int CLOCK_W  = 30;              // clock_hz
	localparam int TW       = PERIOD_W + CLOCK_W; // full product width
	localparam int QW       = 43;              // floor(T / 1e6) always fits here
	localparam int PAD_W    = TW - QW;         // left-align of Q in the divider
	localparam int DVW      = 32;              // divisor width of the divider
	localparam int STEP_W   = $clog2(TW) + 1;  // holds a step count up to TW
	localparam int PD_W     = 16;              // prescale_divisor
	localparam int RC_W     = 32;              // reload_count

	localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(8000000);
	localparam logic [DVW-1:0]     US_PER_SEC  = DVW'(1000000);
	localparam logic [PD_W-1:0]    PD_MAX      = {PD_W{1'b1}};
	localparam logic [RC_W-1:0]    RC_MAX      = {RC_W{1'b1}};

	typedef struct packed {
		logic                start;
		logic [STEP_W-1:0]   steps;
	} div_req_t;

endpackage

// ===== hw/rtl/prr_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module prr_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [prr_pkg::PERIOD_W-1:0]  a,
	input  logic [prr_pkg::CLOCK_W-1:0]   b,
	output logic                          done,
	output logic [prr_pkg::TW-1:0]        product
);

	localparam int CNT_W = $clog2(prr_pkg::PERIOD_W);

	logic [prr_pkg::TW-1:0]      prod_q;
	logic [prr_pkg::CLOCK_W-1:0] b_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [prr_pkg::CLOCK_W:0]   sum;

	// add the multiplicand to the upper half when the low multiplier bit is set
	always_comb begin
		sum = {1'b0, prod_q[prr_pkg::TW-1:prr_pkg::PERIOD_W]}
			+ (prod_q[0] ? {1'b0, b_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(prr_pkg::PERIOD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= {{prr_pkg::CLOCK_W{1'b0}}, a};
			b_q    <= b;
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[prr_pkg::PERIOD_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

// ===== hw/rtl/prr_div.sv =====
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, shared by both divisions.
module prr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prr_pkg::div_req_t          req,
	input  logic [prr_pkg::TW-1:0]     dividend,
	input  logic [prr_pkg::DVW-1:0]    divisor,
	output logic                       done,
	output logic [prr_pkg::TW-1:0]     quotient
);

	logic [prr_pkg::TW-1:0]     dq_q;   // dividend shifts out, quotient shifts in
	logic [prr_pkg::DVW-1:0]    rem_q;
	logic [prr_pkg::DVW-1:0]    div_q;
	logic [prr_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [prr_pkg::DVW:0]      sh;
	logic [prr_pkg::DVW:0]      diff;
	logic                       ge;

	always_comb begin
		sh   = {rem_q, dq_q[prr_pkg::TW-1]};
		diff = sh - {1'b0, div_q};
		ge   = (sh >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps - prr_pkg::STEP_W'(1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - prr_pkg::STEP_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[prr_pkg::TW-2:0], ge};
			rem_q <= ge ? diff[prr_pkg::DVW-1:0] : sh[prr_pkg::DVW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ===== hw/rtl/period_to_prescaler_reload.sv =====
`timescale 1ns / 1ps
// Timer period to prescaler and reload count converter (top level).
// Takes a period in microseconds and, with the clock frequency written on the
// cfg port (reset 8 MHz), returns the smallest prescaler p >= 1 such that
// floor(period * clock / (1e6 * p)) fits the count limit, the matching reload
// count (never 0), and a flag when p had to be clamped at its limit. One item
// is worked on at a time; after the input is accepted it passes the bit-serial
// multiplier, the restoring divider for the division by one million, the
// prescaler and launch states, and the divider again for the count division.
// out_valid rises once the output register is free and the result is loaded
// into it. The output register frees the input side as soon as the result is
// loaded, so the next item may start while the result waits to be taken.
module period_to_prescaler_reload #(
	parameter int COUNT_LIMIT_BITS    = 16,
	parameter int PRESCALE_LIMIT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [prr_pkg::CLOCK_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prr_pkg::PERIOD_W-1:0]  timer_period,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prr_pkg::PD_W-1:0]      prescale_divisor,
	output logic [prr_pkg::RC_W-1:0]      reload_count,
	output logic                          prescale_clamped
);

	localparam int CB  = COUNT_LIMIT_BITS;
	localparam int PB  = PRESCALE_LIMIT_BITS;
	localparam int PRW = prr_pkg::QW - CB + 1;
	localparam logic [63:0] PMAX = (64'd1 << PB) - 64'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV1,
		S_PRE,
		S_LAUNCH,
		S_DIV2,
		S_OUT
	} state_t;

	state_t                       state_q;
	logic [prr_pkg::CLOCK_W-1:0]  clock_q;
	logic [prr_pkg::QW-1:0]       q_q;
	logic [PB-1:0]                presc_q;
	logic                         clamp_q;
	logic                         out_valid_q;
	logic [prr_pkg::PD_W-1:0]     pd_q;
	logic [prr_pkg::RC_W-1:0]     rc_q;
	logic                         pc_q;

	logic                         in_acc;
	logic                         out_load;
	logic                         mul_done;
	logic [prr_pkg::TW-1:0]       product;
	prr_pkg::div_req_t            div_req;
	logic [prr_pkg::TW-1:0]       div_dividend;
	logic [prr_pkg::DVW-1:0]      div_divisor;
	logic                         div_done;
	logic [prr_pkg::TW-1:0]       quotient;

	logic [PRW-1:0]               presc_raw;
	logic                         presc_over;
	logic [PB-1:0]                presc_next;
	logic [prr_pkg::QW-1:0]       count_raw;
	logic [prr_pkg::RC_W-1:0]     count_out;
	logic [prr_pkg::PD_W-1:0]     pd_out;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	prr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc),
		.a       (timer_period),
		.b       (clock_q),
		.done    (mul_done),
		.product (product)
	);

	// first pass divides T by one million, second divides Q by the prescaler
	always_comb begin
		div_req.start = (state_q == S_MUL && mul_done) || (state_q == S_LAUNCH);
		div_req.steps = (state_q == S_MUL) ? prr_pkg::STEP_W'(prr_pkg::TW)
		                                   : prr_pkg::STEP_W'(prr_pkg::QW);
		div_dividend  = (state_q == S_MUL) ? product
		                                   : {q_q, {prr_pkg::PAD_W{1'b0}}};
		div_divisor   = (state_q == S_MUL) ? prr_pkg::US_PER_SEC
		                                   : prr_pkg::DVW'(presc_q);
	end

	prr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		presc_raw  = PRW'(q_q[prr_pkg::QW-1:CB]) + PRW'(1);
		presc_over = (64'(presc_raw) > PMAX);
		presc_next = presc_over ? PB'(PMAX) : PB'(presc_raw);

		count_raw = quotient[prr_pkg::QW-1:0];
		if (|count_raw[prr_pkg::QW-1:prr_pkg::RC_W]) begin
			count_out = prr_pkg::RC_MAX;
		end else if (count_raw == '0) begin
			count_out = prr_pkg::RC_W'(1);
		end else begin
			count_out = count_raw[prr_pkg::RC_W-1:0];
		end

		pd_out = (64'(presc_q) > 64'(prr_pkg::PD_MAX)) ? prr_pkg::PD_MAX
		                                               : prr_pkg::PD_W'(presc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clock_q     <= prr_pkg::CLOCK_RESET;
			q_q         <= '0;
			presc_q     <= '0;
			clamp_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pd_q        <= '0;
			rc_q        <= '0;
			pc_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				clock_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						q_q     <= quotient[prr_pkg::QW-1:0];
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					presc_q <= presc_next;
					clamp_q <= presc_over;
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						pd_q    <= pd_out;
						rc_q    <= count_out;
						pc_q    <= clamp_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign prescale_divisor = pd_q;
	assign reload_count     = rc_q;
	assign prescale_clamped = pc_q;

endmodule

// ===== hw/rtl/prr_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the prescaler calculator, bound to the top level.
module prr_chk #(
	parameter int COUNT_LIMIT_BITS    = 16,
	parameter int PRESCALE_LIMIT_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [prr_pkg::PD_W-1:0]      prescale_divisor,
	input logic [prr_pkg::RC_W-1:0]      reload_count,
	input logic                          prescale_clamped
);

	localparam logic [63:0] CMAX = (64'd1 << COUNT_LIMIT_BITS) - 64'd1;
	localparam logic [63:0] PMAX = (64'd1 << PRESCALE_LIMIT_BITS) - 64'd1;
	localparam logic [prr_pkg::PD_W-1:0] PD_CLAMP =
		(PMAX > 64'(prr_pkg::PD_MAX)) ? prr_pkg::PD_MAX : prr_pkg::PD_W'(PMAX);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prescale_divisor)
			&& $stable(reload_count) && $stable(prescale_clamped))
		else $error("result changed while stalled");

	// one item at a time: input closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input reopened during conversion");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> prescale_divisor != '0 && reload_count != '0)
		else $error("zero prescaler or reload count");

	a_clamp_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prescale_clamped |-> prescale_divisor == PD_CLAMP)
		else $error("clamped prescaler not at its limit");

	a_count_fit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !prescale_clamped |-> 64'(reload_count) <= CMAX)
		else $error("unclamped count exceeds limit");

endmodule

bind period_to_prescaler_reload prr_chk #(
	.COUNT_LIMIT_BITS    (COUNT_LIMIT_BITS),
	.PRESCALE_LIMIT_BITS (PRESCALE_LIMIT_BITS)
) u_prr_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.prescale_divisor (prescale_divisor),
	.reload_count     (reload_count),
	.prescale_clamped (prescale_clamped)
);

// ===== bench/timer_setup_checker.sv =====
`timescale 1ns / 1ps
// Checker for the prescaler calculator: predicts every timer setup and compares results.
module timer_setup_checker #(
	parameter int COUNT_LIMIT_BITS    = 16,
	parameter int PRESCALE_LIMIT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [prr_pkg::CLOCK_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [prr_pkg::PERIOD_W-1:0]  timer_period,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [prr_pkg::PD_W-1:0]      prescale_divisor,
	input  logic [prr_pkg::RC_W-1:0]      reload_count,
	input  logic                          prescale_clamped,
	output int unsigned                   mismatches,
	output int unsigned                   pending
);
	import prr_pkg::*;

	localparam int unsigned PRINT_CAP = 50;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [PD_W-1:0]     divisor;
		logic [RC_W-1:0]     reload;
		logic                clamped;
	} timer_setup_t;

	timer_setup_t       expected_setups[$];
	logic [CLOCK_W-1:0] clock_hz;

	function automatic timer_setup_t timer_setup_for(input logic [PERIOD_W-1:0] period,
			input logic [CLOCK_W-1:0] hz);
		timer_setup_t s;
		logic [63:0]  ticks;
		logic [63:0]  divisor;
		logic [63:0]  reload;
		logic [63:0]  divisor_limit;
		ticks = (64'(period) * 64'(hz)) / 64'(US_PER_SEC);
		divisor = (ticks >> COUNT_LIMIT_BITS) + 64'd1;
		divisor_limit = (64'd1 << PRESCALE_LIMIT_BITS) - 64'd1;
		s.clamped = 1'b0;
		if (divisor > divisor_limit) begin
			divisor = divisor_limit;
			s.clamped = 1'b1;
		end
		reload = ticks / divisor;
		if (reload == 64'd0)
			reload = 64'd1;
		// saturate rather than wrap into the output fields
		if (divisor > 64'(PD_MAX))
			divisor = 64'(PD_MAX);
		if (reload > 64'(RC_MAX))
			reload = 64'(RC_MAX);
		s.period = period;
		s.divisor = divisor[PD_W-1:0];
		s.reload = reload[RC_W-1:0];
		return s;
	endfunction

	task automatic flag(input string what, input logic [PERIOD_W-1:0] period,
			input logic [63:0] got, input logic [63:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch: %s, period %0d: got %0d, expected %0d",
				$realtime, what, period, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_setup_t want;
		if (!arst_n) begin
			clock_hz = CLOCK_RESET;
			expected_setups.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				clock_hz = cfg_data;
			if (in_valid && in_ready)
				expected_setups.push_back(timer_setup_for(timer_period, clock_hz));
			if (out_valid && out_ready) begin
				if (expected_setups.size() == 0) begin
					flag("result with no item outstanding", '0, 64'(reload_count), '0);
				end else begin
					want = expected_setups.pop_front();
					if (prescale_divisor !== want.divisor)
						flag("prescale_divisor", want.period, 64'(prescale_divisor),
							64'(want.divisor));
					if (reload_count !== want.reload)
						flag("reload_count", want.period, 64'(reload_count),
							64'(want.reload));
					if (prescale_clamped !== want.clamped)
						flag("prescale_clamped", want.period, 64'(prescale_clamped),
							64'(want.clamped));
				end
			end
			pending = expected_setups.size();
		end
	end

endmodule

// ===== bench/period_to_prescaler_reload_test.sv =====
`timescale 1ns / 1ps
// Top of the prescaler calculator bench: clock, reset, stimulus and verdict.
module period_to_prescaler_reload_test;
	import prr_pkg::*;

	localparam int COUNT_LIMIT_BITS    = 16;
	localparam int PRESCALE_LIMIT_BITS = 16;
	localparam int RANDOM_PHASES       = 9;
	localparam int ITEMS_PER_PHASE     = 100;
	localparam int DRAIN_CYCLES        = 300;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CLOCK_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [PERIOD_W-1:0] timer_period;
	logic                out_valid;
	logic                out_ready;
	logic [PD_W-1:0]     prescale_divisor;
	logic [RC_W-1:0]     reload_count;
	logic                prescale_clamped;

	int unsigned         mismatches;
	int unsigned         pending;
	bit                  calm;
	logic [CLOCK_W-1:0]  hz_now;

	period_to_prescaler_reload #(
		.COUNT_LIMIT_BITS(COUNT_LIMIT_BITS),
		.PRESCALE_LIMIT_BITS(PRESCALE_LIMIT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.timer_period(timer_period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.prescale_divisor(prescale_divisor),
		.reload_count(reload_count),
		.prescale_clamped(prescale_clamped)
	);

	timer_setup_checker #(
		.COUNT_LIMIT_BITS(COUNT_LIMIT_BITS),
		.PRESCALE_LIMIT_BITS(PRESCALE_LIMIT_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.timer_period(timer_period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.prescale_divisor(prescale_divisor),
		.reload_count(reload_count),
		.prescale_clamped(prescale_clamped),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// mostly short gaps, now and then a long one, none at all while calm
	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(12, 60);
	endfunction

	function automatic logic [CLOCK_W-1:0] pick_clock();
		case ($urandom_range(0, 5))
			0: return CLOCK_W'($urandom_range(1, 1000));
			1: return CLOCK_W'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return CLOCK_W'(32768);
					1: return CLOCK_W'(8000000);
					2: return CLOCK_W'(48000000);
					default: return CLOCK_W'(1000000000);
				endcase
			end
			3: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return CLOCK_W'(1);
					default: return '1;
				endcase
			end
			4: return CLOCK_W'($urandom_range(1, 1000000000));
			default: return CLOCK_W'($urandom >> $urandom_range(2, 31));
		endcase
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period(input logic [CLOCK_W-1:0] hz);
		int unsigned r;
		logic [63:0] target;
		logic [63:0] p;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom;
		if (r < 65)
			return $urandom >> $urandom_range(0, 31);
		if (r < 80)
			return $urandom_range(0, 2000);
		if (hz == '0)
			return $urandom;
		// land the tick count right at a prescaler step, up to the clamp point
		target = 64'($urandom_range(1, 65536)) * (64'd1 << COUNT_LIMIT_BITS) - 64'd1
			+ 64'($urandom_range(0, 2));
		p = (target * 64'(US_PER_SEC) + 64'(hz) - 64'd1) / 64'(hz);
		if (p > 64'hFFFF_FFFF)
			return $urandom;
		return p[PERIOD_W-1:0];
	endfunction

	task automatic send_period(input logic [PERIOD_W-1:0] p);
		in_valid <= 1'b1;
		timer_period <= p;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic issue(input logic [PERIOD_W-1:0] p);
		int unsigned gap;
		send_period(p);
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_clock(input logic [CLOCK_W-1:0] hz);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= hz;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		hz_now = hz;
	endtask

	initial begin
		int unsigned hold;
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold == 0 && $urandom_range(0, 3) == 0)
				hold = idle_len();
			if (hold != 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		timer_period = '0;
		calm = 1'b0;
		hz_now = CLOCK_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset clock: zero period, extremes, first prescaler step
		issue(32'd0);
		issue(32'd1);
		issue(32'hFFFF_FFFF);
		issue(32'd8191);
		issue(32'd8192);
		issue(32'd1000);

		// 1 MHz makes ticks equal the period: probe step and clamp edges
		set_clock(CLOCK_W'(1000000));
		issue(32'd65535);
		issue(32'd65536);
		issue(32'd4294901759);
		issue(32'd4294901760);
		issue(32'hFFFF_FFFF);
		issue(32'hAAAA_AAAA);
		issue(32'h5555_5555);

		// zero clock gives no ticks at all
		set_clock('0);
		issue(32'hFFFF_FFFF);
		issue(32'd12345);

		// slowest clock: counts below one round up
		set_clock(CLOCK_W'(1));
		issue(32'd1);
		issue(32'd999999);
		issue(32'd1000000);
		issue(32'hFFFF_FFFF);

		set_clock('1);
		issue(32'hFFFF_FFFF);
		issue(32'd1);
		issue(32'd0);

		set_clock(CLOCK_W'(1000000000));
		issue(32'hFFFF_FFFF);
		issue(32'd65);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_clock(pick_clock());
			calm = (ph == 2) || ($urandom_range(0, 5) == 0);
			repeat (ITEMS_PER_PHASE)
				issue(pick_period(hz_now));
		end

		calm = 1'b0;
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
